// File: rtl/lprl_pkg.sv
// Shared types, codes and a helper function for the longest-prefix route lookup.
package lprl_pkg;

  // Operation codes carried by the cmd field.
  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_APPEND = 2'd2
  } cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNREACH = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  localparam logic [31:0] AllOnes = 32'hffff_ffff;

  // One stored route.
  typedef struct packed {
    logic [31:0] network;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [1:0]  device;
  } route_t;

  // Best match found so far by the scan.
  typedef struct packed {
    logic        found;
    logic [31:0] gateway;
    logic [1:0]  device;
    logic [5:0]  bits;
  } best_t;

  // Count of set bits in a 32-bit word: eight nibble counts, then a short sum.
  function automatic logic [5:0] popcount32(input logic [31:0] x);
    logic [2:0] nib [8];
    logic [5:0] sum;
    for (int n = 0; n < 8; n++) begin
      nib[n] = 3'(x[4*n]) + 3'(x[4*n+1]) + 3'(x[4*n+2]) + 3'(x[4*n+3]);
    end
    sum = '0;
    for (int n = 0; n < 8; n++) begin
      sum = sum + 6'(nib[n]);
    end
    return sum;
  endfunction

endpackage

// File: rtl/lprl_table.sv
// Route table memory: one write port, one read port, registered read data.
module lprl_table
  import lprl_pkg::*;
#(
  parameter int Depth = 8,
  parameter int IdxW  = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  route_t          wr_data_i,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output logic            rd_valid_o,
  output route_t          rd_data_o
);

  route_t mem_q [Depth];
  route_t rd_data_q;
  logic   rd_valid_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; the data is registered and appears in the cycle after the read enable.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Read-data valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= rd_en_i;
    end
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_data_o  = rd_data_q;

endmodule

// File: rtl/lprl_match.sv
// Match stage and best-route tracking for the table scan.
module lprl_match
  import lprl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dest_i,
  input  logic        entry_valid_i,
  input  route_t      entry_i,
  output logic        busy_o,
  output best_t       best_o
);

  logic        cand_vld_q;
  logic        cand_match_q;
  logic [5:0]  cand_bits_q;
  logic [31:0] cand_gateway_q;
  logic [1:0]  cand_device_q;
  logic        best_found_q;
  logic [31:0] best_gateway_q;
  logic [1:0]  best_device_q;
  logic [5:0]  best_bits_q;
  logic        take;

  // Stage one: address match and mask popcount of the entry just read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_vld_q <= 1'b0;
    end else begin
      cand_vld_q <= entry_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (entry_valid_i) begin
      cand_match_q   <= ((dest_i & entry_i.mask) == entry_i.network);
      cand_bits_q    <= popcount32(entry_i.mask);
      cand_gateway_q <= entry_i.gateway;
      cand_device_q  <= entry_i.device;
    end
  end

  // Stage two: keep the first entry with the strictly largest prefix.
  assign take = cand_vld_q && cand_match_q &&
                (!best_found_q || (cand_bits_q > best_bits_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_found_q <= 1'b0;
    end else if (start_i) begin
      best_found_q <= 1'b0;
    end else if (take) begin
      best_found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !start_i) begin
      best_gateway_q <= cand_gateway_q;
      best_device_q  <= cand_device_q;
      best_bits_q    <= cand_bits_q;
    end
  end

  assign busy_o = cand_vld_q;
  assign best_o = '{found: best_found_q, gateway: best_gateway_q,
                    device: best_device_q, bits: best_bits_q};

endmodule

// File: rtl/longest_prefix_route_lookup.sv
// Top level of the longest-prefix route lookup: control, route count and result register.
//
//   Channel  | Handshake                     | Payload
//   ---------+-------------------------------+----------------------------------------------
//   in       | in_valid_i / in_stall_o       | cmd, dest_address, broadcast, new_* fields
//   out      | out_valid_o / out_stall_i     | status, next_hop, out_device, prefix_bits
//   cfg      | cfg_valid_i / cfg_ready_o     | cfg_data_i (broadcast device)
//
// Clear, append, broadcast, unknown commands and lookups on an empty table go from the
// accept into the result register and then into the output register. A table lookup
// reads one stored route per cycle from the table memory, then registers its result; the
// single read port sets the pace of the scan. The next item is taken once the result has
// moved to the output register. One item is in work at a time; the result register lets
// the next item be accepted while a finished result is still stalled at the output.
// Reset empties the route table count and clears the broadcast device to zero.
module longest_prefix_route_lookup
  import lprl_pkg::*;
#(
  parameter int ROUTE_ENTRIES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] dest_address_i,
  input  logic        broadcast_i,
  input  logic [31:0] new_network_i,
  input  logic [31:0] new_mask_i,
  input  logic [31:0] new_gateway_i,
  input  logic [1:0]  new_device_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] next_hop_o,
  output logic [1:0]  out_device_o,
  output logic [5:0]  prefix_bits_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i
);

  localparam int CntW = $clog2(ROUTE_ENTRIES + 1);
  localparam int IdxW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam logic [CntW-1:0] Entries = CntW'(ROUTE_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] issue_q;
  logic [1:0]      bcast_dev_q;
  logic [31:0]     dest_q;
  logic [1:0]      res_status_q;
  logic [31:0]     res_hop_q;
  logic [1:0]      res_dev_q;
  logic [5:0]      res_bits_q;
  logic            out_vld_q;
  logic [1:0]      out_status_q;
  logic [31:0]     out_hop_q;
  logic [1:0]      out_dev_q;
  logic [5:0]      out_bits_q;

  logic   in_acc;
  logic   wr_en;
  logic   rd_en;
  logic   rd_vld;
  route_t rd_data;
  route_t wr_data;
  logic   match_busy;
  best_t  best;
  logic   scan_done;
  logic   out_free;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_vld_q || !out_stall_i;

  // Appends write the table at the entry indexed by the current count, while the table is not full.
  assign wr_en   = in_acc && (cmd_i == CMD_APPEND) && (count_q < Entries);
  assign wr_data = '{network: new_network_i, mask: new_mask_i,
                     gateway: new_gateway_i, device: new_device_i};

  // One table read per cycle while routes remain below the count.
  assign rd_en     = (state_q == S_SCAN) && (issue_q < count_q);
  assign scan_done = (state_q == S_SCAN) && !rd_en && !rd_vld && !match_busy;

  lprl_table #(
    .Depth (ROUTE_ENTRIES),
    .IdxW  (IdxW)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_addr_i  (count_q[IdxW-1:0]),
    .wr_data_i  (wr_data),
    .rd_en_i    (rd_en),
    .rd_addr_i  (issue_q[IdxW-1:0]),
    .rd_valid_o (rd_vld),
    .rd_data_o  (rd_data)
  );

  lprl_match u_match (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (in_acc),
    .dest_i        (dest_q),
    .entry_valid_i (rd_vld),
    .entry_i       (rd_data),
    .busy_o        (match_busy),
    .best_o        (best)
  );

  // The configuration register is always ready.
  assign cfg_ready_o = 1'b1;

  // Control state, route count, pending result and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      issue_q      <= '0;
      bcast_dev_q  <= 2'd0;
      out_vld_q    <= 1'b0;
      res_status_q <= ST_OK;
      res_hop_q    <= '0;
      res_dev_q    <= '0;
      res_bits_q   <= '0;
      dest_q       <= '0;
      out_status_q <= ST_OK;
      out_hop_q    <= '0;
      out_dev_q    <= '0;
      out_bits_q   <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        bcast_dev_q <= cfg_data_i;
      end
      if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            dest_q       <= dest_address_i;
            issue_q      <= '0;
            res_status_q <= ST_OK;
            res_hop_q    <= '0;
            res_dev_q    <= '0;
            res_bits_q   <= '0;
            state_q      <= S_RESULT;
            case (cmd_i)
              CMD_CLEAR: begin
                count_q <= '0;
              end
              CMD_APPEND: begin
                if (count_q < Entries) begin
                  count_q <= count_q + CntW'(1);
                end else begin
                  res_status_q <= ST_FULL;
                end
              end
              CMD_LOOKUP: begin
                if (broadcast_i) begin
                  res_hop_q <= AllOnes;
                  res_dev_q <= bcast_dev_q;
                end else if (count_q == '0) begin
                  res_status_q <= ST_UNREACH;
                end else begin
                  state_q <= S_SCAN;
                end
              end
              default: begin
                // Unused command: route count and table unchanged, all-zero result.
              end
            endcase
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            issue_q <= issue_q + CntW'(1);
          end
          if (scan_done) begin
            state_q <= S_RESULT;
            if (best.found) begin
              res_hop_q  <= (best.gateway != '0) ? best.gateway : dest_q;
              res_dev_q  <= best.device;
              res_bits_q <= best.bits;
            end else begin
              res_status_q <= ST_UNREACH;
            end
          end
        end
        S_RESULT: begin
          if (out_free) begin
            out_vld_q    <= 1'b1;
            out_status_q <= res_status_q;
            out_hop_q    <= res_hop_q;
            out_dev_q    <= res_dev_q;
            out_bits_q   <= res_bits_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = out_status_q;
  assign next_hop_o    = out_hop_q;
  assign out_device_o  = out_dev_q;
  assign prefix_bits_o = out_bits_q;

  // The route count never passes the table depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Entries)
    else $error("route count exceeds table depth");

  // The count does not move while a scan is running.
  a_count_stable_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && $past(state_q == S_SCAN) |-> $stable(count_q))
    else $error("route count changed during a scan");

  // A table write only ever lands below the depth.
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (count_q != '0) && (count_q <= Entries))
    else $error("table write outside the table");

  // A lookup result never carries the table-full status.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_done |=> (res_status_q == ST_OK) || (res_status_q == ST_UNREACH))
    else $error("scan produced a wrong status");

endmodule
